FILE: hdl/brb_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the byte ring buffer with burst admission.
// No dependencies; imported by brb_ctrl and byte_ring_buffer_burst.
package brb_pkg;

	localparam int CFG_W = 11;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	localparam logic [1:0] CFG_LEN  = 2'd0;
	localparam logic [1:0] CFG_THR  = 2'd1;
	localparam logic [1:0] CFG_PORT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	typedef struct packed {
		logic       rd;
		logic       last;
		logic       acc;
		logic [6:0] count;
		logic       kick;
		logic [7:0] port;
		logic       fso;
		logic [9:0] level;
	} res_t;

endpackage

FILE: hdl/brb_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/brb_ctrl.sv
`timescale 1ns / 1ps
// Ring index, burst admission and read streaming control for the byte ring buffer.
// Depends on brb_pkg; drives the ring memory ports and the result register.
module brb_ctrl import brb_pkg::*; #(
	parameter int RING_DEPTH = 1024,
	parameter int MAX_BURST  = 64,
	localparam int IDX_W = $clog2(RING_DEPTH),
	localparam int LEN_W = $clog2(RING_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             req_type,
	input  logic [7:0]       data_byte,
	input  logic [6:0]       burst_length,
	input  logic [6:0]       read_length,
	input  logic [LEN_W-1:0] ring_len,
	input  logic [9:0]       frame_thr,
	input  logic [7:0]       port_id,
	input  logic             idx_clear,
	output logic             busy,
	output logic             ram_we,
	output logic [IDX_W-1:0] ram_waddr,
	output logic [7:0]       ram_wdata,
	output logic             ram_re,
	output logic [IDX_W-1:0] ram_raddr,
	output logic             res_valid,
	output res_t             res
);

	state_t           state_q;
	logic [IDX_W-1:0] wr_idx_q, rd_idx_q, level_q;
	logic [6:0]       rem_q, total_q, cnt_q, left_q;
	logic             ok_q;
	logic             res_valid_q;
	res_t             res_q;

	logic             accept, is_write, is_read;
	logic             new_burst, wr_ok;
	logic [6:0]       bl, wr_total, wr_rem, want, rd_cnt;
	logic [LEN_W-1:0] free_cur, free_next;
	logic [IDX_W-1:0] lvl_next, wr_idx_nxt, rd_idx_nxt;
	logic             fso_next;
	res_t             res_d;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
		input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] n;
		n = LEN_W'(i) + LEN_W'(1);
		return (n >= len) ? '0 : IDX_W'(n);
	endfunction

	assign accept   = start && (state_q == ST_IDLE);
	assign is_write = accept && (req_type == REQ_WRITE);
	assign is_read  = accept && (req_type == REQ_READ);
	assign busy     = (state_q == ST_READ);

	assign free_cur = ring_len - LEN_W'(level_q) - LEN_W'(1);

	always_comb begin
		if (burst_length == 7'd0) begin
			bl = 7'd1;
		end else if (32'(burst_length) > MAX_BURST) begin
			bl = 7'(MAX_BURST);
		end else begin
			bl = burst_length;
		end
		want = (32'(read_length) > MAX_BURST) ? 7'(MAX_BURST) : read_length;
		rd_cnt = (32'(want) <= 32'(level_q)) ? want : 7'(level_q);
	end

	assign new_burst = (rem_q == 7'd0);
	assign wr_ok     = new_burst ? (32'(free_cur) >= 32'(bl)) : ok_q;
	assign wr_total  = new_burst ? bl : total_q;
	assign wr_rem    = (new_burst ? bl : rem_q) - 7'd1;

	assign wr_idx_nxt = next_idx(wr_idx_q, ring_len);
	assign rd_idx_nxt = next_idx(rd_idx_q, ring_len);

	// level after this result, then free-space test against the frame threshold
	always_comb begin
		if (busy) begin
			lvl_next = level_q - IDX_W'(1);
		end else if (is_write && wr_ok) begin
			lvl_next = level_q + IDX_W'(1);
		end else begin
			lvl_next = level_q;
		end
		free_next = ring_len - LEN_W'(lvl_next) - LEN_W'(1);
		fso_next  = (32'(free_next) >= 32'(frame_thr));
	end

	assign ram_we    = is_write && wr_ok;
	assign ram_waddr = wr_idx_q;
	assign ram_wdata = data_byte;
	assign ram_re    = busy;
	assign ram_raddr = rd_idx_q;

	always_comb begin
		res_d       = '0;
		res_d.fso   = fso_next;
		res_d.level = 10'(lvl_next);
		if (busy) begin
			res_d.rd    = 1'b1;
			res_d.last  = (left_q == 7'd1);
			res_d.count = (left_q == 7'd1) ? cnt_q : 7'd0;
		end else if (is_write) begin
			res_d.acc = wr_ok;
			if (wr_rem == 7'd0) begin
				res_d.last  = 1'b1;
				res_d.count = wr_ok ? wr_total : 7'd0;
				res_d.kick  = wr_ok;
				res_d.port  = wr_ok ? port_id : 8'd0;
			end
		end else begin
			// empty read: one result flagged last
			res_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			level_q     <= '0;
			rem_q       <= '0;
			total_q     <= '0;
			ok_q        <= 1'b0;
			cnt_q       <= '0;
			left_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// a read that finds data answers only from its streaming cycles
			res_valid_q <= busy || is_write || (is_read && rd_cnt == 7'd0);
			if (idx_clear) begin
				wr_idx_q <= '0;
				rd_idx_q <= '0;
				level_q  <= '0;
				ok_q     <= 1'b0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (is_write) begin
							rem_q   <= wr_rem;
							total_q <= wr_total;
							ok_q    <= wr_ok;
							level_q <= lvl_next;
							if (wr_ok) begin
								wr_idx_q <= wr_idx_nxt;
							end
						end else if (is_read && rd_cnt != 7'd0) begin
							cnt_q   <= rd_cnt;
							left_q  <= rd_cnt;
							state_q <= ST_READ;
						end
					end
					ST_READ: begin
						// advance one byte per cycle until the request is drained
						rd_idx_q <= rd_idx_nxt;
						level_q  <= lvl_next;
						left_q   <= left_q - 7'd1;
						if (left_q == 7'd1) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy || accept) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: hdl/byte_ring_buffer_burst.sv
`timescale 1ns / 1ps
// Top level of the byte ring buffer with burst admission: configuration registers,
// ring memory (brb_ram) and control (brb_ctrl). Depends on brb_pkg.

// A write byte is answered by one result on the following cycle; writes may be
// issued back to back. A read request of n bytes (n being the smallest of the
// request, MAX_BURST and the fill level) holds busy until its n bytes are read,
// one ring memory read per cycle, and its results appear one per cycle once the
// read state is entered and the memory read data and result registers are loaded.
// A read that finds nothing answers one empty result on the next cycle and does
// not raise busy. Results are shown for exactly one cycle on result_strobe and
// cannot be held off, so the receiver must take every one of them. Configuration
// takes effect at once and must only be written while no request is in flight.
module byte_ring_buffer_burst import brb_pkg::*; #(
	parameter int RING_DEPTH = 1024,
	parameter int MAX_BURST  = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             req_type,
	input  logic [7:0]       data_byte,
	input  logic [6:0]       burst_length,
	input  logic [6:0]       read_length,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             result_strobe,
	output logic [7:0]       data_out,
	output logic             data_valid,
	output logic             last,
	output logic             accepted,
	output logic [6:0]       done_count,
	output logic             send_kick,
	output logic [7:0]       kick_port,
	output logic             frame_space_ok,
	output logic [9:0]       fill_level
);

	localparam int IDX_W   = $clog2(RING_DEPTH);
	localparam int LEN_W   = $clog2(RING_DEPTH + 1);
	localparam int LEN_RST = (1024 > RING_DEPTH) ? RING_DEPTH : 1024;

	logic [LEN_W-1:0] len_q, len_d;
	logic [9:0]       thr_q;
	logic [7:0]       port_q;
	logic             len_wr;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;
	res_t             res;

	assign len_wr = cfg_write && (cfg_index == CFG_LEN);

	// clamp the ring length to the range the memory supports
	always_comb begin
		if (cfg_data < CFG_W'(2)) begin
			len_d = LEN_W'(2);
		end else if (32'(cfg_data) > RING_DEPTH) begin
			len_d = LEN_W'(RING_DEPTH);
		end else begin
			len_d = LEN_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(LEN_RST);
			thr_q  <= 10'd256;
			port_q <= 8'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LEN:  len_q  <= len_d;
				CFG_THR:  thr_q  <= cfg_data[9:0];
				CFG_PORT: port_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	brb_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	brb_ctrl #(
		.RING_DEPTH(RING_DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.burst_length (burst_length),
		.read_length  (read_length),
		.ring_len     (len_q),
		.frame_thr    (thr_q),
		.port_id      (port_q),
		.idx_clear    (len_wr),
		.busy         (busy),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.res_valid    (result_strobe),
		.res          (res)
	);

	assign data_out       = res.rd ? ram_rdata : 8'd0;
	assign data_valid     = res.rd;
	assign last           = res.last;
	assign accepted       = res.acc;
	assign done_count     = res.count;
	assign send_kick      = res.kick;
	assign kick_port      = res.port;
	assign frame_space_ok = res.fso;
	assign fill_level     = res.level;

endmodule
